@@ rtl/gbn_pkg.sv @@
// Shared types and constants for the go-back-n sender window unit.
// No dependencies; imported by every module of the unit.
`default_nettype none

package gbn_pkg;

  // Default sizing of the unit.
  localparam int PKG_MAX_WINDOW = 32;
  localparam int PKG_FRAME_BITS = 16;

  // Fixed widths of the port fields.
  localparam int FIELD_W   = 16;  // frame_number, ack_number, frame_total
  localparam int WSZ_W     = 6;   // window_size register
  localparam int FUNC_W    = 2;
  localparam int CFG_IDX_W = 1;

  // Register reset values.
  localparam logic [FIELD_W-1:0] FRAME_TOTAL_RST = FIELD_W'(8);
  localparam logic [WSZ_W-1:0]   WINDOW_SIZE_RST = WSZ_W'(4);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_TOTAL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 1'b1;

  // Event codes of the input word.
  typedef logic [FUNC_W-1:0] func_t;
  localparam func_t FN_START   = 2'd0;
  localparam func_t FN_ACK     = 2'd1;
  localparam func_t FN_TIMEOUT = 2'd2;

  // Result kinds.
  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_EXIT  = 1'b1;

  // Commands from the controller to the datapath.
  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_LOAD,
    CMD_START,
    CMD_ACK,
    CMD_TMO,
    CMD_STEP
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    func_t func;       // event code of the held input word
    logic  active;     // a session is open
    logic  more;       // the burst cursor is below its bound
    logic  last_step;  // the next burst word is the final one
    logic  slot_free;  // the output register can take a word this cycle
    logic  ack_emit;   // the held acknowledgement produces a result
  } status_t;

endpackage : gbn_pkg

`default_nettype wire

@@ rtl/gbn_ctrl.sv @@
// Sequencing state machine of the go-back-n sender window unit.
// Depends on gbn_pkg for the command and status types.
`default_nettype none

module gbn_ctrl
  import gbn_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  input  wire status_t st,
  output cmd_t         cmd,
  output logic         in_ready
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_DECODE = 3'b010,
    S_BURST  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NOP;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd       = CMD_LOAD;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (st.func)
          FN_START: begin
            cmd       = CMD_START;
            state_nxt = S_BURST;
          end
          FN_ACK: begin
            if (!st.active) begin
              state_nxt = S_IDLE;
            end else if (!st.ack_emit || st.slot_free) begin
              cmd       = CMD_ACK;
              state_nxt = S_IDLE;
            end
          end
          FN_TIMEOUT: begin
            if (!st.active) begin
              state_nxt = S_IDLE;
            end else begin
              cmd       = CMD_TMO;
              state_nxt = S_BURST;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_BURST: begin
        if (!st.more) begin
          state_nxt = S_IDLE;
        end else if (st.slot_free) begin
          cmd = CMD_STEP;
          if (st.last_step) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule : gbn_ctrl

`default_nettype wire

@@ rtl/gbn_dp.sv @@
// Window state, burst cursor and output register of the go-back-n sender.
// Depends on gbn_pkg; driven by commands from gbn_ctrl.
`default_nettype none

module gbn_dp
  import gbn_pkg::*;
#(
  parameter int FRAME_BITS = PKG_FRAME_BITS,
  parameter int WS_W       = 6
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cmd_t               cmd,
  input  wire func_t              in_func,
  input  wire logic [FIELD_W-1:0] in_ack_number,
  input  wire logic [FIELD_W-1:0] frame_total,
  input  wire logic [WS_W-1:0]    ws,
  input  wire logic               out_ready,
  output status_t                 st,
  output logic                    out_valid,
  output logic                    out_kind,
  output logic [FIELD_W-1:0]      out_frame_number,
  output logic                    out_last
);

  localparam int FB1   = FRAME_BITS + 1;
  localparam int BND_W = ((FRAME_BITS > WS_W) ? FRAME_BITS : WS_W) + 1;

  func_t                 func_r;
  logic [FRAME_BITS-1:0] ack_r;
  logic [FRAME_BITS-1:0] next_r, base_r, top_r, cur_r, bound_r;
  logic                  active_r;
  logic                  out_valid_r, out_kind_r, out_last_r;
  logic [FIELD_W-1:0]    out_frame_r;

  logic [FRAME_BITS-1:0] nf, base_adv, ws_m1, start_cnt, tmo_bound;
  logic [BND_W-1:0]      lim;
  logic                  exit_hit, room, ack_emit, slot_free, emit;

  always_comb begin
    nf        = FRAME_BITS'(frame_total);
    exit_hit  = (FB1'(ack_r) + FB1'(1)) == FB1'(nf);
    base_adv  = (ack_r == base_r) ? base_r + FRAME_BITS'(1) : base_r;
    ws_m1     = FRAME_BITS'(ws - WS_W'(1));
    room      = ((top_r - base_adv) != ws_m1) && (next_r != nf);
    ack_emit  = exit_hit || room;
    // A start sends min(frames, window) frames.
    start_cnt = (BND_W'(nf) < BND_W'(ws)) ? nf : FRAME_BITS'(ws);
    // A timeout resends from the base up to base + window, capped by the total.
    lim       = BND_W'(base_r) + BND_W'(ws);
    tmo_bound = (BND_W'(nf) < lim) ? nf : FRAME_BITS'(lim);
    slot_free = !out_valid_r || out_ready;
    emit      = (cmd == CMD_STEP) || ((cmd == CMD_ACK) && ack_emit);
  end

  always_comb begin
    st.func      = func_r;
    st.active    = active_r;
    st.more      = cur_r < bound_r;
    st.last_step = (cur_r + FRAME_BITS'(1)) == bound_r;
    st.slot_free = slot_free;
    st.ack_emit  = ack_emit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      func_r      <= FN_START;
      ack_r       <= '0;
      next_r      <= '0;
      base_r      <= '0;
      top_r       <= '0;
      cur_r       <= '0;
      bound_r     <= '0;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd)
        CMD_LOAD: begin
          func_r <= in_func;
          ack_r  <= FRAME_BITS'(in_ack_number);
        end
        CMD_START: begin
          base_r   <= '0;
          top_r    <= ws_m1;
          active_r <= 1'b1;
          next_r   <= start_cnt;
          cur_r    <= '0;
          bound_r  <= start_cnt;
        end
        CMD_ACK: begin
          if (exit_hit) begin
            active_r <= 1'b0;
          end else begin
            base_r <= base_adv;
            if (room) begin
              top_r  <= top_r + FRAME_BITS'(1);
              next_r <= next_r + FRAME_BITS'(1);
            end
          end
        end
        CMD_TMO: begin
          cur_r   <= base_r;
          bound_r <= tmo_bound;
        end
        CMD_STEP: begin
          cur_r <= cur_r + FRAME_BITS'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // Output word payload; only loaded when a word is produced.
  always_ff @(posedge clk) begin
    if (cmd == CMD_STEP) begin
      out_kind_r  <= KIND_FRAME;
      out_frame_r <= FIELD_W'(cur_r);
      out_last_r  <= st.last_step;
    end else if (cmd == CMD_ACK && ack_emit) begin
      out_kind_r  <= exit_hit ? KIND_EXIT : KIND_FRAME;
      out_frame_r <= exit_hit ? '0 : FIELD_W'(next_r);
      out_last_r  <= 1'b1;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_frame_number = out_frame_r;
  assign out_last         = out_last_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (!out_valid_r || out_ready))
    else $error("output word overwritten before it was taken");

  a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == CMD_STEP) |-> (cur_r < bound_r))
    else $error("burst step past its bound");

  a_step_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == CMD_STEP) |=> (out_valid_r && out_kind_r == KIND_FRAME))
    else $error("burst step did not produce a frame word");

  a_close_by_ack: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(active_r) |-> (!$past(rst_n) || $past(cmd) == CMD_ACK))
    else $error("session closed without an acknowledgement");

endmodule : gbn_dp

`default_nettype wire

@@ rtl/go_back_n_sender_window_unit.sv @@
// Top level of the go-back-n sender window unit: configuration registers,
// controller and datapath. Depends on gbn_pkg, gbn_ctrl and gbn_dp.
`default_nettype none

// Channel   Direction  Handshake                  Payload
// in        input      in_valid / in_ready        in_func, in_ack_number
// out       output     out_valid / out_ready      out_kind, out_frame_number, out_last
// cfg       input      cfg_valid / cfg_ready      cfg_index, cfg_data
//
// A word is taken in one cycle and decoded in the next, where an acknowledgement or an
// ignored word ends. A start or a timeout then bursts one frame per cycle while out_ready
// stays high. A stalled out_ready holds the burst in the output register without loss; the
// next word is taken once the previous one is issued.
// Reset (rst_n low, synchronous) closes the session, empties the output register and loads
// frame_total with 8 and window_size with 4. The cfg port is always ready.

module go_back_n_sender_window_unit
  import gbn_pkg::*;
#(
  parameter int MAX_WINDOW = PKG_MAX_WINDOW,
  parameter int FRAME_BITS = PKG_FRAME_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [FUNC_W-1:0]    in_func,
  input  wire logic [FIELD_W-1:0]   in_ack_number,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_kind,
  output logic [FIELD_W-1:0]        out_frame_number,
  output logic                      out_last,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [FIELD_W-1:0]   cfg_data
);

  // Width that holds the effective window size, up to MAX_WINDOW.
  localparam int WS_W = $clog2(MAX_WINDOW + 1);

  logic [FIELD_W-1:0] frame_total_r;
  logic [WSZ_W-1:0]   window_size_r;
  logic [WSZ_W:0]     wsz;
  logic [WS_W-1:0]    ws;
  cmd_t               cmd;
  status_t            st;

  // Configuration writes take effect at once; the port never stalls.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_total_r <= FRAME_TOTAL_RST;
      window_size_r <= WINDOW_SIZE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FRAME_TOTAL: frame_total_r <= cfg_data;
        REG_WINDOW_SIZE: window_size_r <= cfg_data[WSZ_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Effective window: a size of zero acts as one, and large sizes saturate.
  always_comb begin
    wsz = {1'b0, window_size_r};
    if (wsz == '0) begin
      ws = WS_W'(1);
    end else if (wsz > (WSZ_W + 1)'(MAX_WINDOW)) begin
      ws = WS_W'(MAX_WINDOW);
    end else begin
      ws = WS_W'(wsz);
    end
  end

  gbn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .st       (st),
    .cmd      (cmd),
    .in_ready (in_ready)
  );

  gbn_dp #(
    .FRAME_BITS (FRAME_BITS),
    .WS_W       (WS_W)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_func          (in_func),
    .in_ack_number    (in_ack_number),
    .frame_total      (frame_total_r),
    .ws               (ws),
    .out_ready        (out_ready),
    .st               (st),
    .out_valid        (out_valid),
    .out_kind         (out_kind),
    .out_frame_number (out_frame_number),
    .out_last         (out_last)
  );

endmodule : go_back_n_sender_window_unit

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the go-back-n sender window unit.
// Depends on gbn_pkg and go_back_n_sender_window_unit; nothing else is read.
`timescale 1ns / 1ps

import gbn_pkg::*;

// One result word as the block emits it.
typedef struct packed {
  logic               kind;
  logic [FIELD_W-1:0] frame;
  logic               last;
} gbn_result_t;

// Window tracker and store of expected result words. It keeps its own copy of
// the session state and of both registers and turns every accepted input word
// into the result words that the sender must emit for it.
class gbn_scoreboard;
  logic [FIELD_W-1:0] frames_cfg;
  logic [WSZ_W-1:0]   wsize_cfg;
  logic [FIELD_W-1:0] next_new;
  logic [FIELD_W-1:0] base;
  logic [FIELD_W-1:0] top;
  logic               resent;
  logic               active;
  gbn_result_t        expected_q[$];
  int                 errors;
  int                 checked;

  function new();
    frames_cfg = FRAME_TOTAL_RST;
    wsize_cfg  = WINDOW_SIZE_RST;
    next_new   = '0;
    base       = '0;
    top        = '0;
    resent     = 1'b0;
    active     = 1'b0;
    errors     = 0;
    checked    = 0;
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [FIELD_W-1:0] data);
    if (idx == REG_FRAME_TOTAL) begin
      frames_cfg = data;
    end else if (idx == REG_WINDOW_SIZE) begin
      wsize_cfg = data[WSZ_W-1:0];
    end
  endfunction

  // A size of zero behaves as one; anything above the maximum is clipped.
  function int unsigned window_len();
    int unsigned w;
    w = wsize_cfg;
    if (w == 0) w = 1;
    if (w > PKG_MAX_WINDOW) w = PKG_MAX_WINDOW;
    return w;
  endfunction

  function void push(logic kind, logic [FIELD_W-1:0] frame, logic last);
    gbn_result_t r;
    r.kind  = kind;
    r.frame = frame;
    r.last  = last;
    expected_q.push_back(r);
  endfunction

  // True when the word reaches the window logic rather than being dropped.
  function bit is_effective(func_t func);
    return (func == FN_START) || (active && (func == FN_ACK || func == FN_TIMEOUT));
  endfunction

  function void note_input(func_t func, logic [FIELD_W-1:0] ack);
    int unsigned ws;
    int unsigned nf;
    int unsigned f;
    int unsigned hi;
    ws = window_len();
    nf = frames_cfg;
    case (func)
      FN_START: begin
        base   = '0;
        top    = FIELD_W'(ws - 1);
        resent = 1'b0;
        active = 1'b1;
        hi = (nf < ws) ? nf : ws;
        for (f = 0; f < hi; f++) push(KIND_FRAME, FIELD_W'(f), f == hi - 1);
        next_new = FIELD_W'(hi);
      end
      FN_ACK: begin
        if (active) begin
          resent = 1'b0;
          // The compare is one bit wider so that an ack of all ones never
          // matches a frame total of zero.
          if ({1'b0, ack} + 17'd1 == {1'b0, frames_cfg}) begin
            push(KIND_EXIT, '0, 1'b1);
            active = 1'b0;
          end else begin
            if (ack == base) base = base + 1'b1;
            if ((top - base) != FIELD_W'(ws - 1) && next_new != frames_cfg) begin
              push(KIND_FRAME, next_new, 1'b1);
              top      = top + 1'b1;
              next_new = next_new + 1'b1;
            end
          end
        end
      end
      FN_TIMEOUT: begin
        if (active) begin
          hi = base + ws;
          if (nf < hi) hi = nf;
          for (f = base; f < hi; f++) push(KIND_FRAME, FIELD_W'(f), f == hi - 1);
          resent = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  function void check_result(logic kind, logic [FIELD_W-1:0] frame, logic last);
    gbn_result_t e;
    checked++;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result word kind=%0d frame=%0d last=%0d",
               $time, kind, frame, last);
      errors++;
    end else begin
      e = expected_q.pop_front();
      if (e.kind !== kind) begin
        $display("%0t: kind mismatch: expected %0d, actual %0d", $time, e.kind, kind);
        errors++;
      end
      if (e.frame !== frame) begin
        $display("%0t: frame_number mismatch: expected %0d, actual %0d",
                 $time, e.frame, frame);
        errors++;
      end
      if (e.last !== last) begin
        $display("%0t: last mismatch: expected %0d, actual %0d", $time, e.last, last);
        errors++;
      end
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module tb_top;

  // Event code that the block must ignore.
  localparam func_t FN_UNUSED = 2'd3;

  // Cycles without any accepted word before the run is declared hung. The
  // slowest legal gap is a receiver stall or a settle pause.
  localparam int IDLE_LIMIT = 2000;
  // Cycles to let the block finish a word that causes no result.
  localparam int SETTLE_CYCLES = 10;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [FUNC_W-1:0]  in_func;
  logic [FIELD_W-1:0] in_ack_number;
  logic               out_valid;
  logic               out_ready;
  logic               out_kind;
  logic [FIELD_W-1:0] out_frame_number;
  logic               out_last;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [FIELD_W-1:0] cfg_data;

  gbn_scoreboard sb;

  // When set, neither side inserts idle cycles.
  bit steady = 1'b0;
  int words_sent = 0;
  int reg_writes = 0;
  int idle_cycles = 0;

  go_back_n_sender_window_unit uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_ack_number    (in_ack_number),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_frame_number (out_frame_number),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // The receiver stalls at random, about one time in five, unless the steady
  // stretch is running.
  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 20);
  end

  // Every result word taken by the receiver is compared with the oldest
  // expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_kind, out_frame_number, out_last);
    end
  end

  // Hang detector: any accepted word on any channel restarts the count.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no word accepted for %0d cycles", $time, IDLE_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Offers one input word, possibly after a few idle cycles, and waits until
  // the block takes it. Valid stays high so a following word can be offered
  // back to back.
  task automatic send_word(func_t func, logic [FIELD_W-1:0] ack);
    while (!steady && $urandom_range(99) < 20) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    in_func       <= func;
    in_ack_number <= ack;
    do @(posedge clk); while (!in_ready);
    sb.note_input(func, ack);
    words_sent++;
  endtask

  // Stops offering words, waits for every expected result and then lets the
  // block finish any word that produced nothing.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [FIELD_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_session(logic [FIELD_W-1:0] frames, logic [FIELD_W-1:0] wdata);
    write_reg(REG_FRAME_TOTAL, frames);
    write_reg(REG_WINDOW_SIZE, wdata);
  endtask

  // Picks the next random word. While a session is open most words are
  // in-order acknowledgements so the window actually slides and sessions end;
  // the rest are timeouts, stray or duplicate acks, restarts and noise.
  task automatic pick_word(output func_t func, output logic [FIELD_W-1:0] ack);
    int unsigned r;
    r    = $urandom_range(99);
    ack  = FIELD_W'($urandom);
    func = FN_ACK;
    if (!sb.active) begin
      if (r < 70) func = FN_START;
      else if (r < 80) func = FN_ACK;
      else if (r < 90) func = FN_TIMEOUT;
      else func = FN_UNUSED;
    end else if (r < 55) begin
      ack = sb.base;
    end else if (r < 62) begin
      ack = sb.frames_cfg - 1'b1;
    end else if (r < 72) begin
      func = FN_TIMEOUT;
    end else if (r < 80) begin
      ack = sb.base + FIELD_W'($urandom_range(0, 4)) - 1'b1;
    end else if (r < 88) begin
      // Leave the fully random acknowledgement.
    end else if (r < 92) begin
      func = FN_UNUSED;
    end else if (r < 96) begin
      func = FN_START;
    end else begin
      func = FN_TIMEOUT;
    end
  endtask

  // Random words until the requested number of them reached the window
  // logic. Optionally the sender holds off halfway until the block is empty.
  task automatic random_phase(int target, bit hold_midway);
    func_t              func;
    logic [FIELD_W-1:0] ack;
    int                 live;
    live = 0;
    while (live < target) begin
      pick_word(func, ack);
      if (sb.is_effective(func)) live++;
      send_word(func, ack);
      if (hold_midway && live == target / 2) begin
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        hold_midway = 1'b0;
      end
    end
  endtask

  initial begin
    logic [FIELD_W-1:0] wdata;
    int                 p;
    sb            = new();
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_func       = FN_START;
    in_ack_number = '0;
    out_ready     = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = REG_FRAME_TOTAL;
    cfg_data      = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: eight frames, window of four. Words before any start
    // must be dropped, as must the unused event code.
    send_word(FN_ACK, 16'h0000);
    send_word(FN_TIMEOUT, 16'hFFFF);
    send_word(FN_UNUSED, 16'h0000);
    send_word(FN_START, 16'hA5A5);
    send_word(FN_ACK, 16'd5);      // not the base and the window is full
    send_word(FN_ACK, 16'd0);      // slides the window, frame 4 goes out
    send_word(FN_TIMEOUT, 16'h5A5A);
    send_word(FN_ACK, 16'hFFFF);
    send_word(FN_START, 16'h0000); // restart in the middle of a session
    send_word(FN_ACK, 16'd7);      // final frame acknowledged, exit marker
    drain();

    // Frame total and window size both zero: nothing is ever sent and no
    // acknowledgement can close the session.
    set_session(16'd0, 16'd0);
    send_word(FN_START, 16'h0000);
    send_word(FN_ACK, 16'hFFFF);
    send_word(FN_TIMEOUT, 16'h0000);
    send_word(FN_ACK, 16'h0000);
    drain();

    // Largest frame total, window register above the maximum: full bursts.
    set_session(16'hFFFF, 16'hFFFF);
    send_word(FN_START, 16'hFFFF);
    send_word(FN_TIMEOUT, 16'hFFFF);
    send_word(FN_ACK, 16'd0);
    send_word(FN_ACK, 16'hFFFE);
    drain();

    // Single frame with the largest window: the first ack ends the session.
    set_session(16'd1, 16'd32);
    send_word(FN_START, 16'h0000);
    send_word(FN_ACK, 16'd0);
    drain();

    // Window larger than the session: bursts are cut at the frame total.
    set_session(16'd3, 16'd5);
    send_word(FN_START, 16'h0000);
    send_word(FN_TIMEOUT, 16'h0000);
    send_word(FN_ACK, 16'd2);
    drain();

    // Random phases, each under its own register settings. The window value
    // carries random upper bits that the register must drop.
    for (p = 0; p < 6; p++) begin
      wdata = FIELD_W'($urandom);
      case (p)
        0: begin
          wdata[WSZ_W-1:0] = WSZ_W'($urandom_range(1, 6));
          set_session(FIELD_W'($urandom_range(2, 12)), wdata);
        end
        1: begin
          wdata[WSZ_W-1:0] = WSZ_W'(32);
          set_session(16'd20, wdata);
        end
        2: begin
          wdata[WSZ_W-1:0] = WSZ_W'(1);
          set_session(FIELD_W'($urandom_range(30, 60)), wdata);
        end
        3: begin
          wdata[WSZ_W-1:0] = WSZ_W'($urandom_range(33, 63));
          set_session(FIELD_W'($urandom_range(0, 3)), wdata);
        end
        4: begin
          wdata[WSZ_W-1:0] = WSZ_W'($urandom_range(0, 63));
          set_session(16'hFFFF, wdata);
        end
        default: begin
          wdata[WSZ_W-1:0] = WSZ_W'($urandom_range(0, 63));
          set_session(FIELD_W'($urandom_range(1, 40)), wdata);
        end
      endcase
      // The third phase runs without any idle cycles on either side.
      steady = (p == 2);
      random_phase(22, p == 1);
      steady = 1'b0;
      drain();
    end

    repeat (20) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d expected result words never arrived", $time, sb.pending());
      sb.errors++;
    end
    $display("Run covered %0d input words, %0d result words and %0d register writes,",
             words_sent, sb.checked, reg_writes);
    $display("across directed corner sessions and six randomized window settings.");
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/gbn_pkg.sv
rtl/gbn_ctrl.sv
rtl/gbn_dp.sv
rtl/go_back_n_sender_window_unit.sv
tb/sv/tb_top.sv
